/* src/plrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrf_pkg
// Shared types, codes and helpers for the piecewise-linear root finder.
// ----------------------------------------------------------------------------
package plrf_pkg;

    // Width of the saturating gradient accumulator
    localparam int ACC_W    = 48;
    // Quotient bits kept by the divider (result range is 0..0x7FFFFFFF)
    localparam int QUO_BITS = 31;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [QUO_BITS-1:0]     POS_MAX = {QUO_BITS{1'b1}};

    // Input request: one hinge pair plus problem scalars
    typedef struct packed {
        logic        [30:0] quad_coef;
        logic signed [31:0] lin_coef;
        logic signed [31:0] start_point;
        logic signed [31:0] slope;
        logic signed [31:0] offset;
        logic               last_item;
    } t_in_req;

    // Output request: one result
    typedef struct packed {
        logic signed [31:0] root;
        logic        [1:0]  outcome;
        logic               saturated;
    } t_out_req;

    // Result kinds
    typedef enum logic [1:0] {
        OUT_START  = 2'd0,
        OUT_BREAK  = 2'd1,
        OUT_LINEAR = 2'd2
    } t_outcome;

    // One sorted breakpoint entry
    typedef struct packed {
        logic [31:0] bp;
        logic [31:0] mag;
    } t_entry;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ITEM,
        ST_BDIV,
        ST_BWAIT,
        ST_INS_RD,
        ST_INS_CMP,
        ST_ITEM_END,
        ST_FINISH,
        ST_S_RD,
        ST_S_MUL,
        ST_S_CMP,
        ST_G_RD,
        ST_G_CHK,
        ST_G_END,
        ST_LDIV,
        ST_LWAIT
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     div_lin;
        logic     bp_latch;
        logic     drop;
        logic     rd;
        logic     rd_prev;
        logic     wr_new;
        logic     wr_shift;
        logic     idx_clr;
        logic     idx_inc;
        logic     mul;
        logic     g_add;
        logic     g_src_rd;
        logic     emit;
        t_outcome emit_sel;
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic bp_valid;
        logic last;
        logic full;
        logic idx_zero;
        logic idx_end;
        logic bp_gt;
        logic eq;
        logic hit;
        logic g_nonneg;
        logic count_zero;
        logic div_done;
    } t_stat;

    typedef struct packed {
        logic signed [ACC_W-1:0] val;
        logic                    ovf;
    } t_acc;

    // Saturating add of a 33-bit signed term into the accumulator
    function automatic t_acc sat_add(input logic signed [ACC_W-1:0] a,
                                     input logic signed [32:0] b);
        logic signed [ACC_W:0] sum;
        t_acc                  res;
        sum = {a[ACC_W-1], a} + {{(ACC_W-32){b[32]}}, b};
        res.ovf = (sum[ACC_W] != sum[ACC_W-1]);
        if (res.ovf) begin
            res.val = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            res.val = sum[ACC_W-1:0];
        end
        return res;
    endfunction

endpackage

/* src/plrf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrf_div
// Restoring divider, one quotient bit per cycle, saturating to 0x7FFFFFFF.
// o_done rises after the last step and holds until the next start.
// ----------------------------------------------------------------------------
module plrf_div #(
    parameter int NUMW = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_force_sat,
    input  logic [NUMW-1:0]               i_num,
    input  logic [31:0]                   i_den,
    output logic                          o_done,
    output logic                          o_sat,
    output logic [plrf_pkg::QUO_BITS-1:0] o_quo
);
    import plrf_pkg::*;

    localparam int HW   = NUMW - QUO_BITS;
    localparam int CMPW = (HW > 32) ? HW : 32;

    logic                r_busy;
    logic [4:0]          r_cnt;
    logic [31:0]         r_rem;
    logic [31:0]         r_den;
    logic [QUO_BITS-1:0] r_low;
    logic [QUO_BITS-1:0] r_quo;
    logic                r_sat;

    logic [CMPW-1:0] high_x;
    logic            sat_now;
    logic [32:0]     trial;
    logic            ge;

    // Quotient overflows when the high part already reaches the divisor
    assign high_x  = CMPW'(i_num >> QUO_BITS);
    assign sat_now = i_force_sat || (high_x >= CMPW'(i_den));
    assign trial   = {r_rem, r_low[QUO_BITS-1]};
    assign ge      = trial >= {1'b0, r_den};

    // Control: r_busy marks that a division has been started
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= sat_now ? 5'd0 : 5'(QUO_BITS);
        end else if (r_busy && r_cnt != 5'd0) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    // Shift-subtract datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_sat <= sat_now;
            r_rem <= 32'(i_num >> QUO_BITS);
            r_low <= i_num[QUO_BITS-1:0];
            r_quo <= sat_now ? POS_MAX : '0;
        end else if (r_busy && r_cnt != 5'd0) begin
            r_rem <= ge ? 32'(trial - {1'b0, r_den}) : trial[31:0];
            r_low <= {r_low[QUO_BITS-2:0], 1'b0};
            r_quo <= {r_quo[QUO_BITS-2:0], ge};
        end
    end

    assign o_done = r_busy && (r_cnt == 5'd0);
    assign o_sat  = r_sat;
    assign o_quo  = r_quo;

endmodule

/* src/plrf_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrf_dpath
// Datapath: accumulator, sorted breakpoint memory, multiplier, divider and
// output register.
// ----------------------------------------------------------------------------
module plrf_dpath #(
    parameter int MAX_POINTS = 1024,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plrf_pkg::t_in_req  i_data,
    input  plrf_pkg::t_cmd     i_cmd,
    output plrf_pkg::t_stat    o_stat,
    output plrf_pkg::t_out_req o_data
);
    import plrf_pkg::*;

    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int NUMW = ACC_W + FRAC_BITS;
    localparam int PW   = 63;
    localparam int CMPW = (NUMW > PW) ? NUMW : PW;

    // Problem state
    logic                    r_open;
    logic [30:0]             r_quad;
    logic signed [31:0]      r_start;
    logic signed [ACC_W-1:0] r_g;
    logic                    r_sat;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_idx;
    logic signed [31:0]      r_slope;
    logic signed [31:0]      r_off;
    logic                    r_last;
    t_entry                  r_new;
    t_entry                  r_rd;
    logic [31:0]             r_p;
    logic [31:0]             r_mag;
    logic [PW-1:0]           r_prod;
    t_out_req                r_out;

    t_entry mem [MAX_POINTS];

    logic signed [ACC_W-1:0] g_base;
    logic                    g_cond;
    t_acc                    load_acc;
    t_acc                    srch_acc;
    logic [31:0]             abs_off;
    logic [31:0]             abs_slope;
    logic [ACC_W-1:0]        n_mag;
    logic                    fits;
    logic [NUMW-1:0]         div_num;
    logic [31:0]             div_den;
    logic                    div_done;
    logic                    div_sat;
    logic [QUO_BITS-1:0]     div_quo;
    logic [CW-1:0]           idx_m1;
    logic [CW-1:0]           rd_idx;
    logic [CW-1:0]           count_max;

    assign count_max = CW'(MAX_POINTS);
    assign idx_m1    = r_idx - CW'(1);
    assign rd_idx    = i_cmd.rd_prev ? idx_m1 : r_idx;

    // Gradient contribution of an incoming pair
    assign g_base   = r_open ? r_g : ACC_W'(i_data.lin_coef);
    assign g_cond   = !i_data.offset[31] &&
                      !((i_data.offset == 32'sd0) && i_data.slope[31]);
    assign load_acc = sat_add(g_base, {i_data.slope[31], i_data.slope});
    assign srch_acc = sat_add(r_g, {1'b0, (i_cmd.g_src_rd ? r_rd.mag : r_mag)});

    assign abs_off   = r_off[31] ? 32'(-r_off) : 32'(r_off);
    assign abs_slope = r_slope[31] ? 32'(-r_slope) : 32'(r_slope);
    assign n_mag     = ACC_W'(-r_g);
    assign fits      = (n_mag >> (64 - FRAC_BITS)) == '0;

    // Divider operand select: breakpoint or linear solve
    assign div_num = i_cmd.div_lin ? (NUMW'(n_mag) << FRAC_BITS)
                                   : (NUMW'(abs_off) << FRAC_BITS);
    assign div_den = i_cmd.div_lin ? {1'b0, r_quad} : abs_slope;

    plrf_div #(
        .NUMW(NUMW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_force_sat(i_cmd.div_lin && !fits),
        .i_num      (div_num),
        .i_den      (div_den),
        .o_done     (div_done),
        .o_sat      (div_sat),
        .o_quo      (div_quo)
    );

    // Control-like problem state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_count <= '0;
            r_g     <= '0;
            r_sat   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_open <= 1'b1;
                if (!r_open) begin
                    r_count <= '0;
                end
                if (g_cond) begin
                    r_g <= load_acc.val;
                end else begin
                    r_g <= g_base;
                end
                r_sat <= (r_open & r_sat) | (g_cond & load_acc.ovf);
            end
            if (i_cmd.bp_latch && div_sat) begin
                r_sat <= 1'b1;
            end
            if (i_cmd.drop) begin
                r_sat <= 1'b1;
            end
            if (i_cmd.wr_new) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.g_add) begin
                r_g <= srch_acc.val;
                if (srch_acc.ovf) begin
                    r_sat <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_open <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (!r_open) begin
                r_quad  <= i_data.quad_coef;
                r_start <= i_data.start_point;
            end
            r_slope <= i_data.slope;
            r_off   <= i_data.offset;
            r_last  <= i_data.last_item;
        end
        if (i_cmd.bp_latch) begin
            r_new.bp  <= {1'b0, div_quo};
            r_new.mag <= abs_slope;
            r_idx     <= r_count;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end
        if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.wr_shift) begin
            r_idx <= idx_m1;
        end
        if (i_cmd.mul) begin
            r_p    <= r_rd.bp;
            r_mag  <= r_rd.mag;
            r_prod <= PW'(r_quad) * PW'(r_rd.bp);
        end
        if (i_cmd.emit) begin
            unique case (i_cmd.emit_sel)
                OUT_START:  r_out.root <= r_start;
                OUT_BREAK:  r_out.root <= r_p;
                OUT_LINEAR: r_out.root <= {1'b0, div_quo};
                default:    r_out.root <= r_start;
            endcase
            r_out.outcome   <= i_cmd.emit_sel;
            r_out.saturated <= r_sat ||
                               ((i_cmd.emit_sel == OUT_LINEAR) && div_sat);
        end
    end

    // Sorted breakpoint memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new || i_cmd.wr_shift) begin
            mem[r_idx[AW-1:0]] <= i_cmd.wr_shift ? r_rd : r_new;
        end
        if (i_cmd.rd || i_cmd.rd_prev) begin
            r_rd <= mem[rd_idx[AW-1:0]];
        end
    end

    // Status
    always_comb begin
        o_stat.bp_valid   = (r_slope != 32'sd0) && (r_off != 32'sd0) &&
                            (r_slope[31] != r_off[31]);
        o_stat.last       = r_last;
        o_stat.full       = (r_count == count_max);
        o_stat.idx_zero   = (r_idx == '0);
        o_stat.idx_end    = (r_idx >= r_count);
        o_stat.bp_gt      = (r_rd.bp > r_new.bp);
        o_stat.eq         = (r_rd.bp == r_p);
        o_stat.hit        = fits &&
                            (CMPW'(r_prod) >= (CMPW'(n_mag) << FRAC_BITS));
        o_stat.g_nonneg   = !r_g[ACC_W-1];
        o_stat.count_zero = (r_count == '0);
        o_stat.div_done   = div_done;
    end

    assign o_data = r_out;

endmodule

/* src/plrf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrf_ctrl
// Controller: sequences load, breakpoint division, sorted insertion, search
// and result hand-off.
// ----------------------------------------------------------------------------
module plrf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  plrf_pkg::t_stat i_stat,
    output plrf_pkg::t_cmd  o_cmd
);
    import plrf_pkg::*;

    t_state   r_state;
    t_state   n_state;
    logic     r_ovalid;
    t_outcome r_sel;
    t_outcome n_sel;

    // State and result-select registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_sel    <= OUT_START;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            if (o_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        n_sel          = r_sel;
        o_cmd          = '0;
        o_cmd.emit_sel = r_sel;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_ITEM;
                end
            end
            ST_ITEM: begin
                if (i_stat.bp_valid) begin
                    n_state = ST_BDIV;
                end else if (i_stat.last) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_BDIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_BWAIT;
            end
            ST_BWAIT: begin
                if (i_stat.div_done) begin
                    if (i_stat.full) begin
                        o_cmd.drop = 1'b1;
                        n_state    = ST_ITEM_END;
                    end else begin
                        o_cmd.bp_latch = 1'b1;
                        n_state        = ST_INS_RD;
                    end
                end
            end
            ST_INS_RD: begin
                if (i_stat.idx_zero) begin
                    o_cmd.wr_new = 1'b1;
                    n_state      = ST_ITEM_END;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                if (i_stat.bp_gt) begin
                    o_cmd.wr_shift = 1'b1;
                    n_state        = ST_INS_RD;
                end else begin
                    o_cmd.wr_new = 1'b1;
                    n_state      = ST_ITEM_END;
                end
            end
            ST_ITEM_END: begin
                n_state = i_stat.last ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                if (i_stat.g_nonneg || i_stat.count_zero) begin
                    n_sel   = OUT_START;
                    n_state = ST_LWAIT;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_S_RD;
                end
            end
            ST_S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_S_MUL;
            end
            ST_S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_S_CMP;
            end
            ST_S_CMP: begin
                if (i_stat.hit) begin
                    n_state = ST_LDIV;
                end else begin
                    o_cmd.g_add   = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_G_RD;
                end
            end
            ST_G_RD: begin
                if (i_stat.idx_end) begin
                    n_state = ST_G_END;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_G_CHK;
                end
            end
            ST_G_CHK: begin
                if (i_stat.eq) begin
                    o_cmd.g_add    = 1'b1;
                    o_cmd.g_src_rd = 1'b1;
                    o_cmd.idx_inc  = 1'b1;
                    n_state        = ST_G_RD;
                end else if (i_stat.g_nonneg) begin
                    n_sel   = OUT_BREAK;
                    n_state = ST_LWAIT;
                end else begin
                    n_state = ST_S_MUL;
                end
            end
            ST_G_END: begin
                if (i_stat.g_nonneg) begin
                    n_sel   = OUT_BREAK;
                    n_state = ST_LWAIT;
                end else begin
                    n_state = ST_LDIV;
                end
            end
            ST_LDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_lin   = 1'b1;
                n_sel           = OUT_LINEAR;
                n_state         = ST_LWAIT;
            end
            ST_LWAIT: begin
                // Wait for the divider (linear root) and a free output slot
                o_cmd.div_lin = (r_sel == OUT_LINEAR);
                if (!r_ovalid && ((r_sel != OUT_LINEAR) || i_stat.div_done)) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_ovalid;

`ifndef SYNTHESIS
    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !r_ovalid)
        else $error("result written over a pending result");

    a_shift_not_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_shift |-> !i_stat.idx_zero)
        else $error("insertion shift below entry zero");

    a_insert_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_new |-> !i_stat.full)
        else $error("insert into a full breakpoint store");

    a_emit_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == ST_IDLE) && r_ovalid)
        else $error("emit did not present a result");
`endif

endmodule

/* src/piecewise_linear_root_finder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_root_finder_unit
// Loads hinge pairs, keeps positive breakpoints sorted, and on the last pair
// of a problem returns the zero of the piecewise-linear gradient.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid/o_stall/i_data) takes one (slope, offset) pair per
//    request; the first pair of a problem also carries quad_coef, lin_coef and
//    start_point. last_item closes the problem and starts the search.
//  - Output channel (o_valid/i_stall/o_data) carries one result per problem.
//  - A pair with a breakpoint goes through the bit-serial divider and is then
//    inserted in sorted order, one shift for every stored breakpoint greater
//    than it (sorted insertion, one memory port).
//  - The search after the last pair walks the sorted breakpoints, taking
//    equal ones together, and may end in a linear solve through the same
//    divider.
//  - One request is worked on at a time; o_stall is high while busy.
//  - After reset no problem is open and no result is pending; the memory
//    needs no clearing.
//  - A result waits in the output register while i_stall is high; the next
//    pair is still accepted and worked on, and only the next result waits.
// ----------------------------------------------------------------------------
module piecewise_linear_root_finder_unit #(
    parameter int MAX_POINTS = 1024,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  plrf_pkg::t_in_req  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output plrf_pkg::t_out_req o_data
);
    import plrf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    plrf_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    plrf_dpath #(
        .MAX_POINTS(MAX_POINTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_data (i_data),
        .i_cmd  (cmd),
        .o_stat (stat),
        .o_data (o_data)
    );

endmodule
